// File: hdl/rk4_planar_pose_integrator_defines.svh
// Assertion macros shared by the pose integrator RTL.
`ifndef RK4_PLANAR_POSE_INTEGRATOR_DEFINES_SVH
`define RK4_PLANAR_POSE_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RK4PPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rk4ppi: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RK4PPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rk4ppi: next-cycle check failed");

`endif

// File: hdl/rk4ppi_pkg.sv
// Shared constants, types and tables of the pose integrator.
`default_nettype none
package rk4ppi_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_STAGES = (CORDIC_ITERATIONS > 30) ? 30 : CORDIC_ITERATIONS;
  localparam int CNT_W = $clog2(CORDIC_STAGES + 1);
  localparam int DIV_STEPS = 10;  // 40-bit dividend, four bits per cycle

  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  localparam logic [15:0] STEP_TIME_RST = 16'd6554;
  localparam logic [31:0] INIT_X_RST = 32'd32768000;
  localparam logic [31:0] INIT_Y_RST = 32'd32768000;
  localparam logic [31:0] INIT_HEADING_RST = 32'd0;

  typedef enum logic [1:0] {
    REG_STEP_TIME    = 2'd0,
    REG_INIT_X       = 2'd1,
    REG_INIT_Y       = 2'd2,
    REG_INIT_HEADING = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_VF_COS = 2'd0,
    MUL_VL_SIN = 2'd1,
    MUL_VF_SIN = 2'd2,
    MUL_VL_COS = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic             cinit;
    logic             citer;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             acc_en;
    mul_sel_t         acc_sel;
    logic             slope;
    logic [1:0]       ang_sel;
    logic [CNT_W-1:0] iter;
    logic             scale;
    logic             div;
    logic             commit;
  } cmd_t;

  function automatic logic [31:0] atan_turns(input logic [CNT_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rk4ppi_if.sv
// Valid/ready channel interfaces for velocity items and pose results.
`default_nettype none
interface rk4ppi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_forward;
  logic signed [31:0] vel_lateral;
  logic signed [31:0] turn_rate;
  modport source (output valid, vel_forward, vel_lateral, turn_rate, input ready);
  modport sink (input valid, vel_forward, vel_lateral, turn_rate, output ready);
endinterface

interface rk4ppi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading;
  logic               saturated;
  modport source (output valid, pos_x, pos_y, heading, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface
`default_nettype wire

// File: hdl/rk4ppi_ctl.sv
// Sequencer: CORDIC, slope products, scaling, divide and commit.
`default_nettype none
module rk4ppi_ctl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output rk4ppi_pkg::cmd_t   cmd,
  output logic               idle
);
  import rk4ppi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CINIT, S_CITER, S_MUL, S_SLOPE, S_SCALE, S_DIV, S_COMMIT
  } state_t;

  state_t           state_r;
  logic [1:0]       ang_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ang_r   <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_CINIT;
            ang_r   <= '0;
          end
        end
        S_CINIT: begin
          state_r <= S_CITER;
          cnt_r   <= '0;
        end
        S_CITER: begin
          if (cnt_r == CNT_W'(CORDIC_STAGES - 1)) begin
            state_r <= S_MUL;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MUL: begin
          if (cnt_r == CNT_W'(4)) state_r <= S_SLOPE;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_SLOPE: begin
          if (ang_r == 2'd2) begin
            state_r <= S_SCALE;
          end else begin
            ang_r   <= ang_r + 1'b1;
            state_r <= S_CINIT;
          end
        end
        S_SCALE: begin
          state_r <= S_DIV;
          cnt_r   <= '0;
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= S_COMMIT;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_COMMIT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.ang_sel = ang_r;
    cmd.iter    = cnt_r;
    cmd.mul_sel = mul_sel_t'(cnt_r[1:0]);
    cmd.acc_sel = mul_sel_t'(cnt_r[1:0] - 2'd1);
    cmd.cinit   = (state_r == S_CINIT);
    cmd.citer   = (state_r == S_CITER);
    cmd.mul_en  = (state_r == S_MUL) && (cnt_r < CNT_W'(4));
    cmd.acc_en  = (state_r == S_MUL) && (cnt_r != '0);
    cmd.slope   = (state_r == S_SLOPE);
    cmd.scale   = (state_r == S_SCALE);
    cmd.div     = (state_r == S_DIV);
    cmd.commit  = (state_r == S_COMMIT);
  end

  assign idle = (state_r == S_IDLE);

endmodule
`default_nettype wire

// File: hdl/rk4ppi_dp.sv
// Datapath: pose registers, CORDIC, shared multiplier, divide by six.
`default_nettype none
module rk4ppi_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rk4ppi_pkg::cmd_t   cmd,
  input  wire logic               start,
  input  wire logic signed [31:0] vel_forward,
  input  wire logic signed [31:0] vel_lateral,
  input  wire logic signed [31:0] turn_rate,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic signed [31:0]      pose_x,
  output logic signed [31:0]      pose_y,
  output logic [31:0]             pose_heading,
  output logic                    sat_flag
);
  import rk4ppi_pkg::*;

  logic [15:0]        dt_r;
  logic signed [31:0] px_r, py_r;
  logic [31:0]        ph_r;
  logic               sat_r;

  logic signed [31:0] vf_r, vl_r;
  logic [31:0]        half_r, full_r;

  logic               flip_r;
  logic signed [32:0] cx_r, cy_r;
  logic signed [33:0] cz_r;

  logic signed [64:0] prod_r;
  logic signed [65:0] ax_r, ay_r;
  logic signed [38:0] sx_r, sy_r;
  logic               negx_r, negy_r;
  logic [39:0]        qx_r, qy_r;
  logic [2:0]         rx_r, ry_r;

  // heading increments for the step
  logic signed [48:0] hp;
  assign hp = turn_rate * $signed({1'b0, dt_r});

  // CORDIC start angle
  logic [31:0] ang, ang_f;
  logic        flip;
  always_comb begin
    unique case (cmd.ang_sel)
      2'd1:    ang = ph_r + half_r;
      2'd2:    ang = ph_r + full_r;
      default: ang = ph_r;
    endcase
    flip  = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    ang_f = flip ? ang - 32'h8000_0000 : ang;
  end

  logic signed [32:0] sh_x, sh_y;
  logic signed [33:0] atan_z;
  assign sh_x   = cx_r >>> cmd.iter;
  assign sh_y   = cy_r >>> cmd.iter;
  assign atan_z = $signed({2'b00, atan_turns(cmd.iter)});

  logic signed [32:0] cos_v, sin_v;
  assign cos_v = flip_r ? -cx_r : cx_r;
  assign sin_v = flip_r ? -cy_r : cy_r;

  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_VF_COS: begin mul_a = vf_r; mul_b = cos_v; end
      MUL_VL_SIN: begin mul_a = vl_r; mul_b = sin_v; end
      MUL_VF_SIN: begin mul_a = vf_r; mul_b = sin_v; end
      default:    begin mul_a = vl_r; mul_b = cos_v; end
    endcase
  end

  // slope rounding, half up
  logic signed [35:0] kx, ky;
  logic signed [65:0] ax_rnd, ay_rnd;
  assign ax_rnd = ax_r + 66'sd536870912;
  assign ay_rnd = ay_r + 66'sd536870912;
  assign kx = 36'(ax_rnd >>> 30);
  assign ky = 36'(ay_rnd >>> 30);

  // scale by dt and fold in the rounding bias
  logic signed [55:0] nx, ny;
  logic [55:0]        mx, my;
  logic [55:0]        bx, by;
  assign nx = sx_r * $signed({1'b0, dt_r});
  assign ny = sy_r * $signed({1'b0, dt_r});
  assign mx = nx[55] ? 56'(-nx) : 56'(nx);
  assign my = ny[55] ? 56'(-ny) : 56'(ny);
  assign bx = mx + 56'd196608;
  assign by = my + 56'd196608;

  // four quotient bits per cycle for each axis
  logic [39:0] qx_n, qy_n;
  logic [2:0]  rx_n, ry_n;
  logic [3:0]  tx, ty;
  always_comb begin
    qx_n = qx_r;
    qy_n = qy_r;
    rx_n = rx_r;
    ry_n = ry_r;
    for (int j = 0; j < 4; j++) begin
      tx = {rx_n, qx_n[39]};
      ty = {ry_n, qy_n[39]};
      if (tx >= 4'd6) begin
        rx_n = 3'(tx - 4'd6);
        qx_n = {qx_n[38:0], 1'b1};
      end else begin
        rx_n = tx[2:0];
        qx_n = {qx_n[38:0], 1'b0};
      end
      if (ty >= 4'd6) begin
        ry_n = 3'(ty - 4'd6);
        qy_n = {qy_n[38:0], 1'b1};
      end else begin
        ry_n = ty[2:0];
        qy_n = {qy_n[38:0], 1'b0};
      end
    end
  end

  // commit with saturation
  logic signed [40:0] dx, dy;
  logic signed [41:0] nxp, nyp;
  logic               ovx, unx, ovy, uny;
  assign dx  = negx_r ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
  assign dy  = negy_r ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
  assign nxp = 42'(px_r) + 42'(dx);
  assign nyp = 42'(py_r) + 42'(dy);
  assign ovx = nxp > 42'sd2147483647;
  assign unx = nxp < -42'sd2147483648;
  assign ovy = nyp > 42'sd2147483647;
  assign uny = nyp < -42'sd2147483648;

  // pose and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r  <= STEP_TIME_RST;
      px_r  <= INIT_X_RST;
      py_r  <= INIT_Y_RST;
      ph_r  <= INIT_HEADING_RST;
      sat_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_TIME:    dt_r <= cfg_data[15:0];
        REG_INIT_X:       px_r <= cfg_data;
        REG_INIT_Y:       py_r <= cfg_data;
        REG_INIT_HEADING: ph_r <= cfg_data;
        default: ;
      endcase
    end else if (cmd.commit) begin
      px_r  <= ovx ? 32'sh7FFF_FFFF : (unx ? 32'sh8000_0000 : nxp[31:0]);
      py_r  <= ovy ? 32'sh7FFF_FFFF : (uny ? 32'sh8000_0000 : nyp[31:0]);
      ph_r  <= ph_r + full_r;
      sat_r <= sat_r | ovx | unx | ovy | uny;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      vf_r   <= vel_forward;
      vl_r   <= vel_lateral;
      half_r <= hp[40:9];
      full_r <= hp[39:8];
    end
    if (cmd.cinit) begin
      flip_r <= flip;
      cx_r   <= CORDIC_START;
      cy_r   <= '0;
      cz_r   <= 34'($signed(ang_f));
    end else if (cmd.citer) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - sh_y;
        cy_r <= cy_r + sh_x;
        cz_r <= cz_r - atan_z;
      end else begin
        cx_r <= cx_r + sh_y;
        cy_r <= cy_r - sh_x;
        cz_r <= cz_r + atan_z;
      end
    end
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.acc_en) begin
      unique case (cmd.acc_sel)
        MUL_VF_COS: ax_r <= 66'(prod_r);
        MUL_VL_SIN: ax_r <= ax_r - 66'(prod_r);
        MUL_VF_SIN: ay_r <= 66'(prod_r);
        default:    ay_r <= ay_r + 66'(prod_r);
      endcase
    end
    if (cmd.slope) begin
      unique case (cmd.ang_sel)
        2'd0: begin sx_r <= 39'(kx); sy_r <= 39'(ky); end
        2'd1: begin sx_r <= sx_r + 39'(kx <<< 2); sy_r <= sy_r + 39'(ky <<< 2); end
        default: begin sx_r <= sx_r + 39'(kx); sy_r <= sy_r + 39'(ky); end
      endcase
    end
    if (cmd.scale) begin
      negx_r <= nx[55];
      negy_r <= ny[55];
      qx_r   <= bx[55:16];
      qy_r   <= by[55:16];
      rx_r   <= '0;
      ry_r   <= '0;
    end else if (cmd.div) begin
      qx_r <= qx_n;
      qy_r <= qy_n;
      rx_r <= rx_n;
      ry_r <= ry_n;
    end
  end

  assign pose_x       = px_r;
  assign pose_y       = py_r;
  assign pose_heading = ph_r;
  assign sat_flag     = sat_r;

endmodule
`default_nettype wire

// File: hdl/rk4_planar_pose_integrator.sv
// Top level of the RK4 planar pose integrator.
`default_nettype none
`include "rk4_planar_pose_integrator_defines.svh"
// Each accepted transaction returns the pose as it stood before the step on
// the next cycle. The block then advances the pose by one RK4 step. For each
// of the three headings it runs a CORDIC setup step, the CORDIC rotations,
// four products on the single shared 32x33 multiplier, each registered
// before it is accumulated, and a slope step. Then come a scaling step, a
// divide-by-six unit that produces four bits per cycle, and a commit step.
// The block is ready again on the cycle after the commit, so it takes no new
// transaction while a step is in progress. A transaction also waits while
// the previous result still sits in the output register and is not taken in
// that cycle. Configuration writes take effect at once and are meant for idle
// periods. Writing an init register loads that pose coordinate, and the
// saturation flag clears only on reset.
module rk4_planar_pose_integrator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rk4ppi_in_if.sink        in_chan,
  rk4ppi_out_if.source     out_chan,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rk4ppi_pkg::*;

  cmd_t               cmd;
  logic               idle;
  logic               in_fire;
  logic signed [31:0] pose_x, pose_y;
  logic [31:0]        pose_heading;
  logic               sat_flag;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [31:0]        out_h_r;
  logic               out_sat_r;

  assign in_chan.ready = idle && (!out_valid_r || out_chan.ready);
  assign in_fire       = in_chan.valid && in_chan.ready;

  rk4ppi_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .cmd   (cmd),
    .idle  (idle)
  );

  rk4ppi_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .start        (in_fire),
    .vel_forward  (in_chan.vel_forward),
    .vel_lateral  (in_chan.vel_lateral),
    .turn_rate    (in_chan.turn_rate),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pose_x       (pose_x),
    .pose_y       (pose_y),
    .pose_heading (pose_heading),
    .sat_flag     (sat_flag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // snapshot of the pose before the step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_x_r   <= pose_x;
      out_y_r   <= pose_y;
      out_h_r   <= pose_heading;
      out_sat_r <= sat_flag;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pos_x     = out_x_r;
  assign out_chan.pos_y     = out_y_r;
  assign out_chan.heading   = out_h_r;
  assign out_chan.saturated = out_sat_r;

  `RK4PPI_ASSERT_NEXT(a_result_follows, in_fire, out_valid_r && !idle)
  `RK4PPI_ASSERT_NOW(a_no_take_busy, !idle, !in_chan.ready)
  `RK4PPI_ASSERT_NOW(a_sat_sticky, 1'b1, !$fell(sat_flag))

endmodule
`default_nettype wire

// File: tb/rk4_planar_pose_integrator_tb_pkg.sv
// Scoreboard class and pose prediction for the pose integrator testbench.
`timescale 1ns / 1ps
package rk4_planar_pose_integrator_tb_pkg;
  import rk4ppi_pkg::*;

  localparam logic [31:0] ATAN_LUT [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic               saturated;
  } pose_t;

  class pose_scoreboard;
    logic [15:0]        dt;
    logic signed [63:0] px, py;
    logic [31:0]        hdg;
    bit                 sat;
    pose_t              pending[$];
    int                 errors;
    int                 checked;

    function void reset_pose();
      dt = STEP_TIME_RST;
      px = $signed(INIT_X_RST);
      py = $signed(INIT_Y_RST);
      hdg = INIT_HEADING_RST;
      sat = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_STEP_TIME:    dt = val[15:0];
        REG_INIT_X:       px = $signed(val);
        REG_INIT_Y:       py = $signed(val);
        REG_INIT_HEADING: hdg = val;
      endcase
    endfunction

    // Rotation-mode CORDIC; >>> on 64-bit signed floors as required.
    function void sincos(logic [31:0] ang, output logic signed [63:0] c,
                         output logic signed [63:0] s);
      logic signed [63:0] x, y, z, nx;
      bit flip;
      flip = (ang[31:30] == 2'd1 || ang[31:30] == 2'd2);
      if (flip) ang = ang - 32'h80000000;
      x = CORDIC_START;
      y = 0;
      z = $signed(ang);
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_LUT[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_LUT[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void rates(logic [31:0] ang, logic signed [63:0] vf, logic signed [63:0] vl,
                        output logic signed [63:0] dx, output logic signed [63:0] dy);
      logic signed [63:0] c, s;
      sincos(ang, c, s);
      dx = (vf * c - vl * s + (64'sd1 <<< 29)) >>> 30;
      dy = (vf * s + vl * c + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function logic signed [63:0] scale_delta(logic signed [63:0] sum);
      logic signed [63:0] num;
      logic [63:0] mag, q;
      num = sum * $signed({48'd0, dt});
      mag = num < 0 ? -num : num;
      q = (mag + 64'd196608) / 64'd393216;
      return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function logic signed [63:0] clamp(logic signed [63:0] r);
      if (r > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
      if (r < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
      return r;
    endfunction

    function void note_velocity(logic signed [31:0] vf, logic signed [31:0] vl,
                                logic signed [31:0] w);
      logic signed [63:0] p, x1, y1, x2, y2, x4, y4;
      logic [31:0] half, full;
      pose_t e;
      p = 64'(w) * $signed({48'd0, dt});
      half = 32'(p >>> 9);
      full = 32'(p >>> 8);
      e.pos_x = px[31:0];
      e.pos_y = py[31:0];
      e.heading = hdg;
      e.saturated = sat;
      pending = {pending, e};
      rates(hdg, vf, vl, x1, y1);
      rates(hdg + half, vf, vl, x2, y2);
      rates(hdg + full, vf, vl, x4, y4);
      px = clamp(px + scale_delta(x1 + 4 * x2 + x4));
      py = clamp(py + scale_delta(y1 + 4 * y2 + y4));
      hdg = hdg + full;
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      if (pending.size() == 0) begin
        $error("unexpected pose transaction x=%0d", got.pos_x);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x: expected %0d, got %0d", e.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y: expected %0d, got %0d", e.pos_y, got.pos_y); errors++;
      end
      if (got.heading !== e.heading) begin
        $error("heading: expected %0h, got %0h", e.heading, got.heading); errors++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated: expected %0b, got %0b", e.saturated, got.saturated); errors++;
      end
    endfunction
  endclass
endpackage

// File: tb/rk4_planar_pose_integrator_test.sv
// Top of the pose integrator testbench: stimulus, configuration and checking.
`timescale 1ns / 1ps
module rk4_planar_pose_integrator_test;
  import rk4ppi_pkg::*;
  import rk4_planar_pose_integrator_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  bit          calm;
  int          sent;

  rk4ppi_in_if  in_chan ();
  rk4ppi_out_if out_chan ();
  pose_scoreboard board;

  rk4_planar_pose_integrator DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("rk4_planar_pose_integrator regression: fail");
    $finish;
  end

  // Result side: random stall bursts, check each transaction.
  initial begin
    pose_t got;
    out_chan.ready = 0;
    board = new();
    board.reset_pose();
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.pos_x = out_chan.pos_x;
        got.pos_y = out_chan.pos_y;
        got.heading = out_chan.heading;
        got.saturated = out_chan.saturated;
        board.check_pose(got);
      end
      if (!calm && out_chan.ready && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk) begin
          if (rst_n && out_chan.valid && out_chan.ready) begin
            got.pos_x = out_chan.pos_x; got.pos_y = out_chan.pos_y;
            got.heading = out_chan.heading; got.saturated = out_chan.saturated;
            board.check_pose(got);
          end
        end
      end
      out_chan.ready <= 1;
    end
  end

  task automatic write_cfg(reg_idx_t idx, logic [31:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  // Drop valid, wait for all results, then let the step computation finish.
  task automatic drain();
    in_chan.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Hold valid after acceptance; the next call or drain decides what follows.
  task automatic send_velocity(logic [31:0] vf, logic [31:0] vl, logic [31:0] w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.vel_forward <= vf;
    in_chan.vel_lateral <= vl;
    in_chan.turn_rate <= w;
    do @(posedge clk); while (!in_chan.ready);
    board.note_velocity(vf, vl, w);
    sent++;
  endtask

  function automatic logic [31:0] pick_vel();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1310720)) - 655360);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  initial begin
    logic [31:0] ext [4] = '{32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000};
    cfg_wr_en = 0; cfg_index = REG_STEP_TIME; cfg_data = 0;
    in_chan.valid = 0; in_chan.vel_forward = 0; in_chan.vel_lateral = 0;
    in_chan.turn_rate = 0;
    calm = 0;
    sent = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset pose, field extremes, heading wrap, saturation.
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_velocity(ext[i], ext[j], ext[(i + j) % 4]);
    send_velocity(32'h00010000, 0, 32'h7FFFFFFF);
    send_velocity(0, 32'hFFFF0000, 32'h80000000);
    drain();
    write_cfg(REG_STEP_TIME, 16'hFFFF);
    write_cfg(REG_INIT_X, 32'h7FFF0000);
    write_cfg(REG_INIT_Y, 32'h80010000);
    write_cfg(REG_INIT_HEADING, 32'hFFFFFF00);
    send_velocity(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00400000);
    send_velocity(32'h80000000, 32'h80000000, 32'hFFC00000);
    send_velocity(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    drain();
    write_cfg(REG_STEP_TIME, 0);
    send_velocity(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_velocity(32'h12345678, 32'h9ABCDEF0, 32'h80000000);

    // Random phases, each with a fresh configuration.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      if (ph == 8) calm = 1;
      case (ph % 3)
        0: write_cfg(REG_STEP_TIME, $urandom_range(0, 65535));
        1: write_cfg(REG_STEP_TIME, STEP_TIME_RST);
        default: write_cfg(REG_STEP_TIME, $urandom_range(0, 1) ? 16'hFFFF : 16'h0001);
      endcase
      write_cfg(REG_INIT_X, $urandom_range(0, 3) == 0 ? $urandom() :
                32'($signed($urandom_range(0, 32'h20000000)) - 32'sh10000000));
      write_cfg(REG_INIT_Y, $urandom_range(0, 3) == 0 ? $urandom() :
                32'($signed($urandom_range(0, 32'h20000000)) - 32'sh10000000));
      write_cfg(REG_INIT_HEADING, $urandom());
      for (int k = 0; k < 125; k++)
        send_velocity(pick_vel(), pick_vel(),
                      $urandom_range(0, 3) == 0 ? $urandom() :
                      32'($signed($urandom_range(0, 33554432)) - 16777216));
    end
    drain();

    $display("Covered %0d velocity transactions, %0d pose results checked,",
             sent, board.checked);
    $display("across extreme and random step times, start poses and headings.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("rk4_planar_pose_integrator regression: pass");
    else
      $display("rk4_planar_pose_integrator regression: fail");
    $finish;
  end
endmodule
